// ----- design/tlpg_pkg.sv -----
// shared types, constants and helpers for the tile-to-led pixel generator
package tlpg_pkg;

    // default sizing
    localparam int NUM_PIXELS_DEF     = 95;
    localparam int NUM_TILE_SLOTS_DEF = 8;

    // field widths
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int SEG_LEN_W = 5;
    localparam int SEGS_W    = 40;
    localparam int PIX_IDX_W = 7;
    localparam int PROD_W    = 16;

    // configuration port
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // register reset values
    localparam logic [CHAN_W-1:0]  BRIGHT_RESET = 8'd180;
    localparam logic [COLOR_W-1:0] SOLID_RESET  = 24'h8000DC;
    localparam logic [SEGS_W-1:0]  SEG_RESET    = 40'd391257665932;

    // item kinds
    localparam logic KIND_TILE_WRITE = 1'b0;
    localparam logic KIND_PIXEL_TICK = 1'b1;

    // register indexes
    typedef enum logic [2:0] {
        REG_STRIP_ON        = 3'd0,
        REG_LIVE_MODE       = 3'd1,
        REG_BRIGHTNESS      = 3'd2,
        REG_SOLID_COLOR     = 3'd3,
        REG_SEGMENT_LENGTHS = 3'd4
    } cfg_reg_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic                strip_on;
        logic                live_mode;
        logic [CHAN_W-1:0]   brightness;
        logic [COLOR_W-1:0]  solid_color;
        logic [SEGS_W-1:0]   segment_lengths;
    } cfg_t;

    // per-pixel tag carried down the pipeline
    typedef struct packed {
        logic [PIX_IDX_W-1:0] pixel_index;
        logic                 frame_end;
        logic                 in_segment;
    } pix_t;

    // led count of one tile
    function automatic logic [SEG_LEN_W-1:0] seg_len(logic [SEGS_W-1:0] segs, logic [2:0] t);
        return segs[int'(t) * SEG_LEN_W +: SEG_LEN_W];
    endfunction

    // (p + 127) / 255 for a product of two 8-bit values
    function automatic logic [CHAN_W-1:0] scale255(logic [PROD_W-1:0] p);
        logic [PROD_W:0] x;
        logic [PROD_W:0] q;
        x = {1'b0, p} + 17'd127;
        q = (x + (x >> 8) + 17'd1) >> 8;
        return q[CHAN_W-1:0];
    endfunction

endpackage

// ----- design/tlpg_in_if.sv -----
// request channel: tile writes and pixel ticks
interface tlpg_in_if;
    import tlpg_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [2:0]        tile_index;
    logic [CHAN_W-1:0] tile_red;
    logic [CHAN_W-1:0] tile_green;
    logic [CHAN_W-1:0] tile_blue;

    modport source (output valid, kind, tile_index, tile_red, tile_green, tile_blue,
                    input ready);
    modport sink   (input valid, kind, tile_index, tile_red, tile_green, tile_blue,
                    output ready);
endinterface

// ----- design/tlpg_out_if.sv -----
// result channel: one scaled pixel per pixel tick
interface tlpg_out_if;
    import tlpg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [CHAN_W-1:0]    out_red;
    logic [CHAN_W-1:0]    out_green;
    logic [CHAN_W-1:0]    out_blue;
    logic                 frame_end;

    modport source (output valid, pixel_index, out_red, out_green, out_blue, frame_end,
                    input ready);
    modport sink   (input valid, pixel_index, out_red, out_green, out_blue, frame_end,
                    output ready);
endinterface

// ----- design/tlpg_cfg.sv -----
// apb configuration registers
module tlpg_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlpg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tlpg_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tlpg_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output tlpg_pkg::cfg_t                  cfg
);
    import tlpg_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    cfg_reg_t reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = cfg_reg_t'(paddr[5:3]);

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_STRIP_ON:        cfg_next.strip_on        = pwdata[0];
                REG_LIVE_MODE:       cfg_next.live_mode       = pwdata[0];
                REG_BRIGHTNESS:      cfg_next.brightness      = pwdata[CHAN_W-1:0];
                REG_SOLID_COLOR:     cfg_next.solid_color     = pwdata[COLOR_W-1:0];
                REG_SEGMENT_LENGTHS: cfg_next.segment_lengths = pwdata[SEGS_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strip_on        <= 1'b0;
            cfg_reg.live_mode       <= 1'b0;
            cfg_reg.brightness      <= BRIGHT_RESET;
            cfg_reg.solid_color     <= SOLID_RESET;
            cfg_reg.segment_lengths <= SEG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (reg_sel)
            REG_STRIP_ON:        prdata = CFG_DATA_W'(cfg_reg.strip_on);
            REG_LIVE_MODE:       prdata = CFG_DATA_W'(cfg_reg.live_mode);
            REG_BRIGHTNESS:      prdata = CFG_DATA_W'(cfg_reg.brightness);
            REG_SOLID_COLOR:     prdata = CFG_DATA_W'(cfg_reg.solid_color);
            REG_SEGMENT_LENGTHS: prdata = CFG_DATA_W'(cfg_reg.segment_lengths);
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/tlpg_tile_mem.sv -----
// tile colour memory, registered read, valid bit per entry
module tlpg_tile_mem #(
    parameter int NUM_TILE_SLOTS = tlpg_pkg::NUM_TILE_SLOTS_DEF,
    parameter int TILE_W         = (NUM_TILE_SLOTS > 1) ? $clog2(NUM_TILE_SLOTS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [TILE_W-1:0]            wr_addr,
    input  logic [tlpg_pkg::COLOR_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [TILE_W-1:0]            rd_addr,
    output logic [tlpg_pkg::COLOR_W-1:0] rd_data
);
    import tlpg_pkg::*;

    logic [COLOR_W-1:0]        tile_mem [NUM_TILE_SLOTS];
    logic [NUM_TILE_SLOTS-1:0] valid_reg;
    logic [NUM_TILE_SLOTS-1:0] valid_next;
    logic [COLOR_W-1:0]        rd_data_reg;
    logic                      rd_valid_reg;

    // storage write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tile_mem[wr_addr] <= wr_data;
        end
    end

    // entries never written read as black
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= tile_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- design/tlpg_walk.sv -----
// strip position and segment walk, issues the tile read
module tlpg_walk #(
    parameter int NUM_PIXELS     = tlpg_pkg::NUM_PIXELS_DEF,
    parameter int NUM_TILE_SLOTS = tlpg_pkg::NUM_TILE_SLOTS_DEF,
    parameter int TILE_W         = (NUM_TILE_SLOTS > 1) ? $clog2(NUM_TILE_SLOTS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick,
    input  logic [tlpg_pkg::SEGS_W-1:0] segment_lengths,
    input  logic                        s1_ready,
    output logic                        rd_en,
    output logic [TILE_W-1:0]           rd_addr,
    output logic                        s1_valid,
    output tlpg_pkg::pix_t              s1_meta
);
    import tlpg_pkg::*;

    localparam int POS_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int CT_W  = $clog2(NUM_TILE_SLOTS + 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_PIXELS - 1);
    localparam logic [CT_W-1:0]  TILE_END = CT_W'(NUM_TILE_SLOTS);

    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [CT_W-1:0]      cur_reg;
    logic [CT_W-1:0]      cur_next;
    logic [SEG_LEN_W-1:0] count_reg;
    logic [SEG_LEN_W-1:0] count_next;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    pix_t                 s1_meta_reg;

    logic [CT_W-1:0]      sel_tile;
    logic                 stay;
    logic                 hit;
    logic                 last;

    // pick the tile that holds this led
    always_comb
    begin
        sel_tile = cur_reg;
        stay     = 1'b0;
        if (cur_reg < TILE_END)
        begin
            stay = count_reg < seg_len(segment_lengths, 3'(cur_reg));
        end
        hit = stay;
        for (int t = 0; t < NUM_TILE_SLOTS; t++)
        begin
            if (!hit && (CT_W'(t) > cur_reg) && (seg_len(segment_lengths, 3'(t)) != '0))
            begin
                sel_tile = CT_W'(t);
                hit      = 1'b1;
            end
        end
        if (!hit)
        begin
            sel_tile = TILE_END;
        end
    end

    assign last = pos_reg >= LAST_POS;

    // walk state update
    always_comb
    begin
        pos_next   = pos_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        if (tick)
        begin
            if (last)
            begin
                pos_next   = '0;
                cur_next   = '0;
                count_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                cur_next = sel_tile;
                if (stay)
                begin
                    count_next = count_reg + SEG_LEN_W'(1);
                end
                else if (hit)
                begin
                    count_next = SEG_LEN_W'(1);
                end
                else
                begin
                    count_next = '0;
                end
            end
        end
    end

    // stage one occupancy
    always_comb
    begin
        if (tick)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            cur_reg      <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            cur_reg      <= cur_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // tag that travels with the memory read
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            s1_meta_reg.pixel_index <= PIX_IDX_W'(pos_reg);
            s1_meta_reg.frame_end   <= last;
            s1_meta_reg.in_segment  <= hit;
        end
    end

    assign rd_en    = tick;
    assign rd_addr  = sel_tile[TILE_W-1:0];
    assign s1_valid = s1_valid_reg;
    assign s1_meta  = s1_meta_reg;

endmodule

// ----- design/tlpg_scale.sv -----
// colour select, brightness multiply and rounding, output register
module tlpg_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s1_valid,
    input  tlpg_pkg::pix_t               s1_meta,
    input  logic [tlpg_pkg::COLOR_W-1:0] tile_color,
    input  tlpg_pkg::cfg_t               cfg,
    output logic                         s1_ready,
    tlpg_out_if.source                   result
);
    import tlpg_pkg::*;

    logic               v2_reg;
    logic               v2_next;
    logic               v3_reg;
    logic               v3_next;
    logic               rdy2;
    logic               rdy3;
    logic               load2;
    logic               load3;
    logic [COLOR_W-1:0] color;

    logic [PROD_W-1:0]    prod_r_reg;
    logic [PROD_W-1:0]    prod_g_reg;
    logic [PROD_W-1:0]    prod_b_reg;
    pix_t                 meta2_reg;
    logic [CHAN_W-1:0]    red_reg;
    logic [CHAN_W-1:0]    green_reg;
    logic [CHAN_W-1:0]    blue_reg;
    pix_t                 meta3_reg;

    // stage handshakes
    assign rdy3     = !v3_reg || result.ready;
    assign rdy2     = !v2_reg || rdy3;
    assign s1_ready = rdy2;
    assign load2    = s1_valid && rdy2;
    assign load3    = v2_reg && rdy3;

    // colour source
    always_comb
    begin
        if (!cfg.strip_on)
        begin
            color = '0;
        end
        else if (!cfg.live_mode)
        begin
            color = cfg.solid_color;
        end
        else if (s1_meta.in_segment)
        begin
            color = tile_color;
        end
        else
        begin
            color = '0;
        end
    end

    always_comb
    begin
        v2_next = load2 ? 1'b1 : (rdy3 ? 1'b0 : v2_reg);
        v3_next = load3 ? 1'b1 : (result.ready ? 1'b0 : v3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // brightness products
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            prod_r_reg <= PROD_W'(color[23:16]) * PROD_W'(cfg.brightness);
            prod_g_reg <= PROD_W'(color[15:8]) * PROD_W'(cfg.brightness);
            prod_b_reg <= PROD_W'(color[7:0]) * PROD_W'(cfg.brightness);
            meta2_reg  <= s1_meta;
        end
    end

    // rounded divide by 255 into the output register
    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            red_reg   <= scale255(prod_r_reg);
            green_reg <= scale255(prod_g_reg);
            blue_reg  <= scale255(prod_b_reg);
            meta3_reg <= meta2_reg;
        end
    end

    assign result.valid       = v3_reg;
    assign result.pixel_index = meta3_reg.pixel_index;
    assign result.out_red     = red_reg;
    assign result.out_green   = green_reg;
    assign result.out_blue    = blue_reg;
    assign result.frame_end   = meta3_reg.frame_end;

endmodule

// ----- design/tile_to_led_pixel_generator.sv -----
// top level of the tile-to-led pixel generator
//
//  channel   dir  handshake        payload
//  item      in   valid/ready      kind, tile_index, tile_red, tile_green, tile_blue
//  result    out  valid/ready      pixel_index, out_red, out_green, out_blue, frame_end
//  apb       in   psel/penable     paddr[5:3] register, pwdata/prdata 64 bits
//
// one request per cycle while the result side keeps up; a tile write takes effect
// at its accepting edge, a pixel tick passes three register stages (tile memory
// read, multiply, round) and its result is offered from the round stage.
// reset marks every tile entry unwritten so it reads black, with no clearing pass.
// a stalled result holds only the stages behind it that are full, so empty stages
// still take requests; with all three full the request side waits.
module tile_to_led_pixel_generator #(
    parameter int NUM_PIXELS     = tlpg_pkg::NUM_PIXELS_DEF,
    parameter int NUM_TILE_SLOTS = tlpg_pkg::NUM_TILE_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tlpg_in_if.sink                         item,
    tlpg_out_if.source                      result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlpg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tlpg_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tlpg_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tlpg_pkg::*;

    localparam int TILE_W = (NUM_TILE_SLOTS > 1) ? $clog2(NUM_TILE_SLOTS) : 1;

    cfg_t               cfg;
    logic               accept;
    logic               tick;
    logic               tile_wr;
    logic               rd_en;
    logic [TILE_W-1:0]  rd_addr;
    logic [COLOR_W-1:0] tile_color;
    logic               s1_valid;
    logic               s1_ready;
    pix_t               s1_meta;

    // request decode
    assign item.ready = !s1_valid || s1_ready;
    assign accept     = item.valid && item.ready;
    assign tick       = accept && (item.kind == KIND_PIXEL_TICK);
    assign tile_wr    = accept && (item.kind == KIND_TILE_WRITE)
                        && (int'(item.tile_index) < NUM_TILE_SLOTS);

    tlpg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlpg_walk #(
        .NUM_PIXELS     (NUM_PIXELS),
        .NUM_TILE_SLOTS (NUM_TILE_SLOTS),
        .TILE_W         (TILE_W)
    ) u_walk (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick            (tick),
        .segment_lengths (cfg.segment_lengths),
        .s1_ready        (s1_ready),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .s1_valid        (s1_valid),
        .s1_meta         (s1_meta)
    );

    tlpg_tile_mem #(
        .NUM_TILE_SLOTS (NUM_TILE_SLOTS),
        .TILE_W         (TILE_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tile_wr),
        .wr_addr (TILE_W'(item.tile_index)),
        .wr_data ({item.tile_red, item.tile_green, item.tile_blue}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (tile_color)
    );

    tlpg_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1_meta    (s1_meta),
        .tile_color (tile_color),
        .cfg        (cfg),
        .s1_ready   (s1_ready),
        .result     (result)
    );

endmodule

// ----- design/tlpg_checker.sv -----
// port-level checks for the pixel generator, bound to the top level
module tlpg_checker #(
    parameter int NUM_PIXELS = tlpg_pkg::NUM_PIXELS_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic                            pready,
    input logic [tlpg_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [tlpg_pkg::CFG_DATA_W-1:0] pwdata,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [tlpg_pkg::PIX_IDX_W-1:0]  pixel_index,
    input logic [tlpg_pkg::CHAN_W-1:0]     out_red,
    input logic [tlpg_pkg::CHAN_W-1:0]     out_green,
    input logic [tlpg_pkg::CHAN_W-1:0]     out_blue,
    input logic                            frame_end
);
    import tlpg_pkg::*;

    logic              power_reg;
    logic [CHAN_W-1:0] bright_reg;
    logic              wr_en;
    logic              black;

    assign wr_en = psel && penable && pwrite && pready;
    assign black = (out_red == '0) && (out_green == '0) && (out_blue == '0);

    // shadow of the registers that force black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg  <= 1'b0;
            bright_reg <= BRIGHT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[5:3] == REG_STRIP_ON)
            begin
                power_reg <= pwdata[0];
            end
            if (paddr[5:3] == REG_BRIGHTNESS)
            begin
                bright_reg <= pwdata[CHAN_W-1:0];
            end
        end
    end

    // frame end marks the last strip position
    a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> pixel_index == PIX_IDX_W'(NUM_PIXELS - 1))
        else $error("frame_end on a pixel other than the last");

    // pixel index stays on the strip
    a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (NUM_PIXELS > 128) || (int'(pixel_index) < NUM_PIXELS))
        else $error("pixel_index beyond the strip");

    // power off gives black
    a_power_off_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !power_reg |-> black)
        else $error("lit pixel while power is off");

    // zero brightness gives black
    a_zero_bright_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (bright_reg == '0) |-> black)
        else $error("lit pixel at zero brightness");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_index) && $stable(out_red)
            && $stable(out_green) && $stable(out_blue) && $stable(frame_end))
        else $error("stalled result changed");

endmodule

bind tile_to_led_pixel_generator tlpg_checker #(
    .NUM_PIXELS (NUM_PIXELS)
) u_tlpg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .pixel_index (result.pixel_index),
    .out_red     (result.out_red),
    .out_green   (result.out_green),
    .out_blue    (result.out_blue),
    .frame_end   (result.frame_end)
);
